[design/sfl_pkg.sv]
// Shared constants, types and codes for the serial line to LED pixel block.
// No dependencies; every other file in this folder imports this package.
package sfl_pkg;

	localparam int BAR_LEDS   = 10;
	localparam int EYE_LEDS   = 8;
	localparam int TOTAL_LEDS = BAR_LEDS + EYE_LEDS;
	localparam int LINE_LEN   = EYE_LEDS + 11;
	localparam int MASK_START = EYE_LEDS + 2;

	localparam int POS_W  = $clog2(LINE_LEN + 2);
	localparam int LED_W  = 5;
	localparam int MASK_W = 12;
	localparam int BIDX_W = (BAR_LEDS > 1) ? $clog2(BAR_LEDS) : 1;
	localparam int EIDX_W = (EYE_LEDS > 1) ? $clog2(EYE_LEDS) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] END_BYTE    = 8'h0D;
	localparam logic [7:0] START_BYTE  = 8'h5E;
	localparam logic [7:0] LETTER_R    = 8'h52;
	localparam logic [7:0] LETTER_G    = 8'h47;
	localparam logic [7:0] LETTER_B    = 8'h42;
	localparam logic [7:0] EYE_LEVEL_RESET = 8'd30;
	localparam logic [7:0] BAR_LEVEL_RESET = 8'd10;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_LEVEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_LEVEL = 1'd1;

	typedef logic [1:0] eye_code_t;
	localparam eye_code_t EYE_OFF   = 2'd0;
	localparam eye_code_t EYE_RED   = 2'd1;
	localparam eye_code_t EYE_GREEN = 2'd2;
	localparam eye_code_t EYE_BLUE  = 2'd3;

	// One ended line as handed from the parser to the pixel emitter.
	typedef struct packed {
		logic                             ok;
		logic [7:0]                       eye_level;
		logic [7:0]                       bar_level;
		logic [EYE_LEDS-1:0][1:0]         eye_codes;
		logic [BAR_LEDS-1:0]              red_mask;
		logic [BAR_LEDS-1:0]              green_mask;
		logic [BAR_LEDS-1:0]              blue_mask;
	} sfl_cmd_t;

endpackage

[design/serial_frame_to_led_pixels_unit.sv]
// Serial line to LED pixel block: parser, command queue and pixel emitter.
// Depends on sfl_pkg, sfl_front, sfl_queue and sfl_back.
//
// Usage:
// Serial bytes enter on in_valid/in_ready/data_byte, one per cycle while
// in_ready is high. Every byte other than carriage return is parsed in the
// cycle it is accepted and gives no output. A carriage return closes the line
// and queues one command; the emitter then sends all 18 stored pixels on
// out_valid/out_ready, one item per cycle while out_ready is high, in LED
// order, with frame_ok telling whether the line was applied and last_pixel
// marking the final item. After the carriage return is accepted the command
// passes through the queue and the emitter's load step before the first pixel
// is registered; out_valid can drop between bursts while the next one loads.
// The queue holds two pending lines; in_ready drops only while it is full,
// so a stalled receiver holds off the serial side once two ended lines wait
// behind the burst in progress.
// Level registers are written through cfg_write/cfg_index/cfg_data; the user
// must do so only while idle, as the block does not enforce it. Reset clears
// the line state and all pixels to off; eye and bar levels go to 30 and 10.
module serial_frame_to_led_pixels_unit import sfl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LED_W-1:0]     led_index,
	output logic [7:0]           green_value,
	output logic [7:0]           blue_value,
	output logic [7:0]           red_value,
	output logic                 frame_ok,
	output logic                 last_pixel
);

	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;
	sfl_cmd_t push_cmd;
	sfl_cmd_t pop_cmd;

	sfl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	sfl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (pop_cmd)
	);

	sfl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (pop_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.led_index   (led_index),
		.green_value (green_value),
		.blue_value  (blue_value),
		.red_value   (red_value),
		.frame_ok    (frame_ok),
		.last_pixel  (last_pixel)
	);

`ifndef SYNTHESIS
	// The final item of a burst is always the highest LED.
	a_last_is_top_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> led_index == LED_W'(TOTAL_LEDS - 1))
		else $error("last pixel flagged on wrong LED");

	// Inside a burst the next pixel follows at once with the next index.
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=>
			out_valid && led_index == $past(led_index) + LED_W'(1))
		else $error("burst broken or index skipped");

	// frame_ok is one value for the whole burst.
	a_ok_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=> frame_ok == $past(frame_ok))
		else $error("frame_ok changed inside a burst");

	// A full queue is the only reason to hold off the serial side.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !q_full)
		else $error("input ready does not follow queue space");
`endif

endmodule

[design/sfl_front.sv]
// Line parser: takes serial bytes, holds the line state and the level registers,
// and pushes one command per carriage return. Depends on sfl_pkg.
module sfl_front import sfl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output sfl_cmd_t             q_cmd
);

	logic [7:0]       eye_level_q;
	logic [7:0]       bar_level_q;
	logic [POS_W-1:0] pos_q;
	logic             start_seen_q;
	logic             early_nul_q;
	logic             nul_at_end_q;
	eye_code_t        eye_codes_q [EYE_LEDS];
	logic [MASK_W-1:0] red_q;
	logic [MASK_W-1:0] green_q;
	logic [MASK_W-1:0] blue_q;

	logic             accept;
	logic             is_end;
	logic [POS_W-1:0] pos_m1;
	logic [POS_W-1:0] kpos;
	logic [EIDX_W-1:0] eye_sel;
	eye_code_t        letter_code;
	logic [3:0]       hex_v;
	logic             line_ok;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
		else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h61 + 8'd10;
		else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h41 + 8'd10;
		return t[3:0];
	endfunction

	// Digit 0 is the most significant of the three.
	function automatic logic [MASK_W-1:0] set_digit(input logic [MASK_W-1:0] m,
			input logic [1:0] d, input logic [3:0] v);
		logic [MASK_W-1:0] r;
		r = m;
		case (d)
			2'd0: r[11:8] = v;
			2'd1: r[7:4] = v;
			default: r[3:0] = v;
		endcase
		return r;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_end   = (data_byte == END_BYTE);
	assign q_push   = accept && is_end;
	assign pos_m1   = pos_q - POS_W'(1);
	assign kpos     = pos_q - POS_W'(MASK_START);
	assign eye_sel  = pos_m1[EIDX_W-1:0];
	assign hex_v    = hex_value(data_byte);
	assign line_ok  = start_seen_q && !early_nul_q &&
		(pos_q == POS_W'(LINE_LEN) || nul_at_end_q);

	always_comb begin
		if (data_byte == LETTER_R) letter_code = EYE_RED;
		else if (data_byte == LETTER_G) letter_code = EYE_GREEN;
		else if (data_byte == LETTER_B) letter_code = EYE_BLUE;
		else letter_code = EYE_OFF;
	end

	always_comb begin
		q_cmd.ok         = line_ok;
		q_cmd.eye_level  = eye_level_q;
		q_cmd.bar_level  = bar_level_q;
		q_cmd.red_mask   = red_q[BAR_LEDS-1:0];
		q_cmd.green_mask = green_q[BAR_LEDS-1:0];
		q_cmd.blue_mask  = blue_q[BAR_LEDS-1:0];
		for (int n = 0; n < EYE_LEDS; n++) begin
			q_cmd.eye_codes[n] = eye_codes_q[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_level_q <= EYE_LEVEL_RESET;
			bar_level_q <= BAR_LEVEL_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_EYE_LEVEL: eye_level_q <= cfg_data;
				REG_BAR_LEVEL: bar_level_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			start_seen_q <= 1'b0;
			early_nul_q  <= 1'b0;
			nul_at_end_q <= 1'b0;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
			for (int n = 0; n < EYE_LEDS; n++) begin
				eye_codes_q[n] <= EYE_OFF;
			end
		end else if (accept) begin
			if (is_end) begin
				pos_q        <= '0;
				start_seen_q <= 1'b0;
				early_nul_q  <= 1'b0;
				nul_at_end_q <= 1'b0;
			end else if (pos_q == POS_W'(LINE_LEN)) begin
				pos_q <= pos_q + POS_W'(1);
				if (data_byte == 8'd0) nul_at_end_q <= 1'b1;
			end else if (pos_q < POS_W'(LINE_LEN)) begin
				// Past the line end the position saturates and bytes are dropped; only the first byte past it is checked for a NUL.
				pos_q <= pos_q + POS_W'(1);
				if (data_byte == 8'd0) early_nul_q <= 1'b1;
				if (pos_q == '0) begin
					start_seen_q <= (data_byte == START_BYTE);
				end else if (pos_q <= POS_W'(EYE_LEDS)) begin
					eye_codes_q[eye_sel] <= letter_code;
				end else if (pos_q >= POS_W'(MASK_START)) begin
					if (kpos < POS_W'(3)) begin
						red_q <= set_digit(red_q, kpos[1:0], hex_v);
					end else if (kpos < POS_W'(6)) begin
						green_q <= set_digit(green_q, 2'(kpos - POS_W'(3)), hex_v);
					end else begin
						blue_q <= set_digit(blue_q, 2'(kpos - POS_W'(6)), hex_v);
					end
				end
			end
		end
	end

endmodule

[design/sfl_queue.sv]
// Short command queue between the line parser and the pixel emitter.
// Depends on sfl_pkg for the command type and the depth.
module sfl_queue import sfl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sfl_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output sfl_cmd_t pop_cmd
);

	sfl_cmd_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

[design/sfl_back.sv]
// Pixel emitter: keeps the last applied line as the pixel store and plays out
// one burst of pixels per queued command. Depends on sfl_pkg.
module sfl_back import sfl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  sfl_cmd_t         q_cmd,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [LED_W-1:0] led_index,
	output logic [7:0]       green_value,
	output logic [7:0]       blue_value,
	output logic [7:0]       red_value,
	output logic             frame_ok,
	output logic             last_pixel
);

	// Pixel store, held as the line that produced it; all zero means all off.
	sfl_cmd_t         store_q;
	logic             busy_q;
	logic             ok_q;
	logic [LED_W-1:0] cnt_q;
	logic             out_valid_q;

	logic             advance;
	logic             cnt_last;
	logic [LED_W-1:0] eye_off;
	logic [BIDX_W-1:0] bar_sel;
	eye_code_t        code;
	logic [7:0]       pix_g;
	logic [7:0]       pix_b;
	logic [7:0]       pix_r;

	assign advance   = !out_valid_q || out_ready;
	assign cnt_last  = (cnt_q == LED_W'(TOTAL_LEDS - 1));
	assign q_pop     = !busy_q && !q_empty;
	assign out_valid = out_valid_q;
	assign eye_off   = cnt_q - LED_W'(BAR_LEDS);
	assign bar_sel   = cnt_q[BIDX_W-1:0];
	assign code      = store_q.eye_codes[eye_off[EIDX_W-1:0]];

	always_comb begin
		if (cnt_q < LED_W'(BAR_LEDS)) begin
			pix_g = store_q.green_mask[bar_sel] ? store_q.bar_level : 8'd0;
			pix_b = store_q.blue_mask[bar_sel] ? store_q.bar_level : 8'd0;
			pix_r = store_q.red_mask[bar_sel] ? store_q.bar_level : 8'd0;
		end else begin
			pix_g = (code == EYE_GREEN) ? store_q.eye_level : 8'd0;
			pix_b = (code == EYE_BLUE) ? store_q.eye_level : 8'd0;
			pix_r = (code == EYE_RED) ? store_q.eye_level : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			busy_q  <= 1'b0;
			ok_q    <= 1'b0;
			cnt_q   <= '0;
		end else if (q_pop) begin
			if (q_cmd.ok) store_q <= q_cmd;
			ok_q   <= q_cmd.ok;
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (advance && busy_q) begin
			cnt_q <= cnt_q + LED_W'(1);
			if (cnt_last) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			led_index   <= cnt_q;
			green_value <= pix_g;
			blue_value  <= pix_b;
			red_value   <= pix_r;
			frame_ok    <= ok_q;
			last_pixel  <= cnt_last;
		end
	end

endmodule
